[hw/rtl/lap5_pkg.sv]
`default_nettype none

package lap5_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 2'd1;

  // grid size after reset, before clamping to the line length
  localparam int GRID_RESET = 1024;

  // width of the reported coordinates
  localparam int COORD_W = 10;

  // pending results of one item, in emission order
  localparam int RES_N     = 3;
  localparam int RES_CELL  = 0;
  localparam int RES_RIGHT = 1;
  localparam int RES_SELF  = 2;

  typedef struct packed {
    logic emit_self;
    logic emit_right;
    logic emit_cell;
    logic cell_border;
  } item_flags_t;

endpackage

`default_nettype wire

[hw/rtl/laplacian_5point_stencil.sv]
// Channel  | Direction | Handshake                  | Payload
// sample   | in        | sample_valid/sample_stall  | sample
// result   | out       | result_valid/result_stall  | out_row, out_col, value, is_border,
//          |           |                            | last_of_run
// cfg      | in        | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// One sample a cycle while each sample yields at most one result and no result is stalled;
// a sample that yields more results holds the input while the result register takes
// them one beat a cycle when not stalled. A result passes from its sample through the
// stage 1 register and the stage 2 pending register into the result register.
// The line buffers read at the sample's column; line_above writes there, line_two at s1_c.
// Reset (rst, synchronous) clears counters, window and handshake state; the line
// buffers need no clearing pass. A stalled result holds the pipeline behind it.
`default_nettype none

module laplacian_5point_stencil
  import lap5_pkg::*;
#(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [COORD_W-1:0]                 out_row,
  output logic [COORD_W-1:0]                 out_col,
  output logic signed [SAMPLE_BITS+2:0]      value,
  output logic                               is_border,
  output logic                               last_of_run,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int SW    = SAMPLE_BITS;
  localparam int VW    = SAMPLE_BITS + 3;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int RST_ROWS = (MAX_ROWS < GRID_RESET) ? MAX_ROWS : GRID_RESET;
  localparam int RST_COLS = (MAX_COLS < GRID_RESET) ? MAX_COLS : GRID_RESET;

  // configuration
  logic [ROW_W:0] grid_rows;
  logic [COL_W:0] grid_cols;
  logic [31:0]    cfg_wide;
  logic [31:0]    rows_wr;
  logic [31:0]    cols_wr;
  logic           cfg_wr;
  logic           restart;

  // position of the next sample
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] r_eff;
  logic [COL_W-1:0] c_eff;
  logic             pos_wrap;
  logic             col_last;
  logic             row_last;
  item_flags_t      flags_in;

  // line buffers
  logic signed [SW-1:0] line_above [MAX_COLS];
  logic signed [SW-1:0] line_two   [MAX_COLS];
  logic signed [SW-1:0] rd_above;
  logic signed [SW-1:0] rd_two;

  // window over the previous rows
  logic signed [SW-1:0] prev_sample;
  logic signed [SW-1:0] win_left;
  logic signed [SW-1:0] win_center;
  logic signed [SW-1:0] win_top;

  // stage 1: line buffer data available
  logic                 s1_valid;
  logic [ROW_W-1:0]     s1_r;
  logic [COL_W-1:0]     s1_c;
  logic signed [SW-1:0] s1_s;
  item_flags_t          s1_flags;
  logic                 fwd_sel;
  logic signed [SW-1:0] fwd_val;
  logic signed [SW-1:0] two_eff;
  logic signed [VW-1:0] lap;
  logic signed [VW-1:0] cell_val;
  logic                 s1_move;

  // stage 2: pending results of one item
  logic [RES_N-1:0]     s2_mask;
  logic [ROW_W-1:0]     s2_r;
  logic [COL_W-1:0]     s2_c;
  logic signed [VW-1:0] s2_vcell;
  logic signed [SW-1:0] s2_vright;
  logic signed [SW-1:0] s2_vself;
  logic                 s2_cell_border;
  logic [RES_N-1:0]     s2_low;
  logic [RES_N-1:0]     s2_mask_after;
  logic                 s2_free;
  logic                 out_load;

  logic accept;

  // configuration write
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && ((cfg_index == REG_GRID_ROWS) || (cfg_index == REG_GRID_COLS));

  always_comb begin
    cfg_wide = 32'(cfg_data);
    if (cfg_wide == 32'd0) begin
      rows_wr = 32'd1;
      cols_wr = 32'd1;
    end else begin
      rows_wr = (cfg_wide > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : cfg_wide;
      cols_wr = (cfg_wide > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cfg_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= (ROW_W+1)'(RST_ROWS);
      grid_cols <= (COL_W+1)'(RST_COLS);
    end else if (cfg_wr) begin
      if (cfg_index == REG_GRID_ROWS) begin
        grid_rows <= (ROW_W+1)'(rows_wr);
      end
      if (cfg_index == REG_GRID_COLS) begin
        grid_cols <= (COL_W+1)'(cols_wr);
      end
    end
  end

  // handshake
  assign s2_low        = s2_mask & (~s2_mask + RES_N'(1));
  assign out_load      = (s2_mask != '0) && (!result_valid || !result_stall);
  assign s2_mask_after = out_load ? (s2_mask & ~s2_low) : s2_mask;
  assign s2_free       = (s2_mask_after == '0);
  assign s1_move       = s1_valid && s2_free;
  assign sample_stall  = s1_valid && !s2_free;
  assign accept        = sample_valid && !sample_stall;

  // position and emission flags of the incoming sample
  always_comb begin
    pos_wrap = ({1'b0, row_cnt} >= grid_rows) || ({1'b0, col_cnt} >= grid_cols);
    r_eff    = pos_wrap ? '0 : row_cnt;
    c_eff    = pos_wrap ? '0 : col_cnt;
    col_last = (({1'b0, c_eff} + (COL_W+1)'(1)) == grid_cols);
    row_last = (({1'b0, r_eff} + (ROW_W+1)'(1)) == grid_rows);
    flags_in.emit_cell   = (r_eff != '0) && (c_eff != '0);
    flags_in.emit_right  = (r_eff != '0) && col_last;
    flags_in.emit_self   = row_last;
    flags_in.cell_border = (r_eff == ROW_W'(1)) || (c_eff == COL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_cnt <= '0;
        row_cnt <= row_last ? '0 : r_eff + ROW_W'(1);
      end else begin
        col_cnt <= c_eff + COL_W'(1);
        row_cnt <= r_eff;
      end
    end
  end

  // line above: read the old entry and write the new sample in the same beat
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_above          <= line_above[c_eff];
      line_above[c_eff] <= sample;
    end
  end

  // line two above: written back as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_two <= line_two[c_eff];
    end
    if (s1_move) begin
      line_two[s1_c] <= rd_above;
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_move);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r     <= r_eff;
      s1_c     <= c_eff;
      s1_s     <= sample;
      s1_flags <= flags_in;
      // the write-back of the item ahead lands in the same beat as this read
      fwd_sel  <= s1_move && (s1_c == c_eff);
      fwd_val  <= rd_above;
    end
  end

  assign two_eff = fwd_sel ? fwd_val : rd_two;

  always_comb begin
    lap = VW'(win_top) + VW'(prev_sample) + VW'(win_left) + VW'(rd_above)
        - (VW'(win_center) <<< 2);
    cell_val = s1_flags.cell_border ? VW'(win_center) : lap;
  end

  // window and left neighbour advance as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      prev_sample <= '0;
      win_left    <= '0;
      win_center  <= '0;
      win_top     <= '0;
    end else if (s1_move) begin
      prev_sample <= s1_s;
      win_left    <= win_center;
      win_center  <= rd_above;
      win_top     <= two_eff;
    end
  end

  // stage 2: pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_mask <= '0;
    end else if (s1_move) begin
      s2_mask[RES_CELL]  <= s1_flags.emit_cell;
      s2_mask[RES_RIGHT] <= s1_flags.emit_right;
      s2_mask[RES_SELF]  <= s1_flags.emit_self;
    end else begin
      s2_mask <= s2_mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_r           <= s1_r;
      s2_c           <= s1_c;
      s2_vcell       <= cell_val;
      s2_vright      <= rd_above;
      s2_vself       <= s1_s;
      s2_cell_border <= s1_flags.cell_border;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      last_of_run <= (s2_mask_after == '0);
      priority if (s2_mask[RES_CELL]) begin
        out_row   <= COORD_W'(s2_r - ROW_W'(1));
        out_col   <= COORD_W'(s2_c - COL_W'(1));
        value     <= s2_vcell;
        is_border <= s2_cell_border;
      end else if (s2_mask[RES_RIGHT]) begin
        out_row   <= COORD_W'(s2_r - ROW_W'(1));
        out_col   <= COORD_W'(s2_c);
        value     <= VW'(s2_vright);
        is_border <= 1'b1;
      end else begin
        out_row   <= COORD_W'(s2_r);
        out_col   <= COORD_W'(s2_c);
        value     <= VW'(s2_vself);
        is_border <= 1'b1;
      end
    end
  end

  // a result that is not the last of its item leaves more behind it
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |-> s2_mask != '0)
    else $error("non-final result with nothing pending");

  // a held stage 1 item keeps its column for the write-back
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_c))
    else $error("stage 1 item lost while held");

  // a read colliding with the write-back takes the forwarded entry
  a_forward: assert property (@(posedge clk) disable iff (rst)
    s1_move && accept && (s1_c == c_eff) |=> fwd_sel && (fwd_val == $past(rd_above)))
    else $error("line buffer collision not forwarded");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import lap5_pkg::*;

  localparam int LINE_LEN     = 1024;
  localparam int ROWS_MAX     = 1024;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_WAIT   = 4;
  localparam int EDGE_ITEMS   = 40;
  localparam int RANDOM_ITEMS = 344;
  localparam int REPORT_MAX   = 10;

  // indexes past the two grid registers; the block ignores them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic signed [18:0] val;
    logic               border;
    logic               run_end;
  } cell_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic signed [15:0]     sample       = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [COORD_W-1:0]     out_row;
  logic [COORD_W-1:0]     out_col;
  logic signed [18:0]     value;
  logic                   is_border;
  logic                   last_of_run;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  // stencil state mirrored on the bench side
  bit signed [15:0]   above_row [LINE_LEN];
  bit signed [15:0]   two_above_row [LINE_LEN];
  logic signed [15:0] left_sample;
  logic signed [15:0] tap_left;
  logic signed [15:0] tap_center;
  logic signed [15:0] tap_top;
  int                 row_pos;
  int                 col_pos;
  int                 n_rows;
  int                 n_cols;

  cell_t              expected_cells[$];
  logic signed [15:0] pending_samples[$];

  int mismatches   = 0;
  int idle_cycles  = 0;
  bit sample_taken = 1'b0;
  bit gaps_on      = 1'b1;
  bit stalls_on    = 1'b1;
  int send_gap     = 0;
  int stall_left   = 0;
  int plan_rows;
  int plan_cols;
  int grid_cells;
  int batch;
  int split;
  int random_sent;

  laplacian_5point_stencil dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .value        (value),
    .is_border    (is_border),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int top);
    if (v == 0) return 1;
    return (v > top) ? top : int'(v);
  endfunction

  function automatic void restart_grid();
    left_sample = '0;
    tap_left    = '0;
    tap_center  = '0;
    tap_top     = '0;
    row_pos     = 0;
    col_pos     = 0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_GRID_ROWS: begin
        n_rows = clamp_dim(d, ROWS_MAX);
        restart_grid();
      end
      REG_GRID_COLS: begin
        n_cols = clamp_dim(d, LINE_LEN);
        restart_grid();
      end
      default: ;
    endcase
  endfunction

  function automatic cell_t make_cell(input int r, input int c, input int v, input bit border);
    cell_t k;
    k.row     = COORD_W'(r);
    k.col     = COORD_W'(c);
    k.val     = 19'(v);
    k.border  = border;
    k.run_end = 1'b0;
    return k;
  endfunction

  // A sample at (r, c) completes cell (r-1, c-1); the right edge and the last row
  // add border copies behind it.
  function automatic void predict_cells(input logic signed [15:0] s);
    cell_t              cells[$];
    logic signed [15:0] up_c;
    logic signed [15:0] up2_c;
    int                 lap;
    up_c  = above_row[col_pos];
    up2_c = two_above_row[col_pos];
    if (row_pos >= 1 && col_pos >= 1) begin
      if (row_pos == 1 || col_pos == 1) begin
        cells.push_back(make_cell(row_pos - 1, col_pos - 1, int'(tap_center), 1'b1));
      end else begin
        lap = int'(tap_top) + int'(left_sample) + int'(tap_left) + int'(up_c)
            - 4 * int'(tap_center);
        cells.push_back(make_cell(row_pos - 1, col_pos - 1, lap, 1'b0));
      end
    end
    if (row_pos >= 1 && col_pos + 1 == n_cols)
      cells.push_back(make_cell(row_pos - 1, col_pos, int'(up_c), 1'b1));
    if (row_pos + 1 == n_rows)
      cells.push_back(make_cell(row_pos, col_pos, int'(s), 1'b1));
    if (cells.size() != 0) cells[cells.size() - 1].run_end = 1'b1;
    foreach (cells[i]) expected_cells.push_back(cells[i]);

    tap_left               = tap_center;
    tap_center             = up_c;
    tap_top                = up2_c;
    two_above_row[col_pos] = up_c;
    above_row[col_pos]     = s;
    left_sample            = s;
    col_pos++;
    if (col_pos >= n_cols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= n_rows) ? 0 : row_pos + 1;
    end
  endfunction

  function automatic void check_cell();
    cell_t got;
    cell_t want;
    got = {out_row, out_col, value, is_border, last_of_run};
    if (expected_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("result beat with nothing expected: row %0d col %0d value %0d border %0b last %0b",
                 got.row, got.col, got.val, got.border, got.run_end);
    end else begin
      want = expected_cells.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch: expected row %0d col %0d value %0d border %0b last %0b",
                   want.row, want.col, want.val, want.border, want.run_end);
          $display("          actual   row %0d col %0d value %0d border %0b last %0b",
                   got.row, got.col, got.val, got.border, got.run_end);
        end
      end
    end
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int pick_dim(input int top);
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 2;
      9:       return $urandom_range(9, top);
      default: return $urandom_range(3, 8);
    endcase
  endfunction

  function automatic logic signed [15:0] next_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // monitor: track the predictor, check result beats, feed the watchdog
  always @(posedge clk) begin
    sample_taken = 1'b0;
    if (rst) begin
      n_rows      = clamp_dim(CFG_DATA_W'(GRID_RESET), ROWS_MAX);
      n_cols      = clamp_dim(CFG_DATA_W'(GRID_RESET), LINE_LEN);
      restart_grid();
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (sample_valid && !sample_stall) begin
        sample_taken = 1'b1;
        predict_cells(sample);
      end
      if (result_valid && !result_stall) check_cell();
      if ((cfg_valid && cfg_ready) || sample_taken || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (sample_valid && !sample_taken) begin
      // hold the beat until it is taken
    end else if (send_gap != 0) begin
      sample_valid <= 1'b0;
      send_gap--;
    end else if (pending_samples.size() != 0) begin
      sample_valid <= 1'b1;
      sample       <= pending_samples.pop_front();
      if (gaps_on && $urandom_range(0, 2) == 0) send_gap = gap_len();
    end else begin
      sample_valid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
    end
    result_stall <= (stall_left != 0);
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // an item may give nothing back, so allow the pipeline to empty after the last result
  task automatic wait_quiet();
    while (pending_samples.size() != 0 || sample_valid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) pending_samples.push_back(next_sample());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // grid after reset is 1024 x 1024, so the first row gives nothing back
    send_random(5);
    wait_quiet();

    // largest positive and negative Laplacian on a 3 x 3 grid, two frames back to back
    write_reg(REG_GRID_ROWS, 11'd3);
    write_reg(REG_GRID_COLS, 11'd3);
    for (int i = 0; i < 9; i++) pending_samples.push_back(i == 4 ? 16'sh8000 : 16'sh7FFF);
    for (int i = 0; i < 9; i++) pending_samples.push_back(i == 4 ? 16'sh7FFF : 16'sh8000);
    wait_quiet();

    // zero rows counts as one: a single-cell grid
    write_reg(REG_GRID_ROWS, '0);
    write_reg(REG_GRID_COLS, 11'd1);
    send_random(2);
    wait_quiet();
    write_reg(REG_SPARE_2, '0);
    write_reg(REG_SPARE_3, '1);
    send_random(1);
    wait_quiet();

    // tall grid one column wide, then a wide grid one row high
    write_reg(REG_GRID_ROWS, '1);
    send_random(EDGE_ITEMS);
    wait_quiet();
    write_reg(REG_GRID_ROWS, 11'd1);
    write_reg(REG_GRID_COLS, 11'd1024);
    send_random(EDGE_ITEMS);
    wait_quiet();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      plan_rows = pick_dim(12);
      plan_cols = pick_dim(30);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_GRID_ROWS, CFG_DATA_W'(plan_rows));
        write_reg(REG_GRID_COLS, CFG_DATA_W'(plan_cols));
      end else begin
        write_reg(REG_GRID_COLS, CFG_DATA_W'(plan_cols));
        write_reg(REG_GRID_ROWS, CFG_DATA_W'(plan_rows));
      end
      grid_cells = plan_rows * plan_cols;
      if (grid_cells > 100)
        batch = grid_cells;
      else
        batch = grid_cells * $urandom_range(1, 2) + $urandom_range(0, grid_cells - 1);
      if (batch > RANDOM_ITEMS - random_sent)
        batch = RANDOM_ITEMS - random_sent;
      // pause the sender mid-frame until every result is home
      split = (random_sent == 0 || $urandom_range(0, 4) == 0) ? batch / 2 : batch;
      send_random(split);
      if (split != batch) begin
        wait_quiet();
        send_random(batch - split);
      end
      random_sent += batch;
      wait_quiet();
    end

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
